// ===== src/rtlp_pkg.sv =====
// constants, types and the character matcher for the radar text line parser
package rtlp_pkg;

    localparam int unsigned LINE_CAPACITY = 32;
    localparam int unsigned CNT_W         = $clog2(LINE_CAPACITY);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(LINE_CAPACITY - 1);

    localparam logic [31:0] LIMIT_RESET = 32'd5000;
    localparam logic [16:0] ACC_SAT     = 17'd65536;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UP_O  = 8'h4F;
    localparam logic [7:0] CH_UP_N  = 8'h4E;
    localparam logic [7:0] CH_UP_F  = 8'h46;
    localparam logic [7:0] CH_UP_R  = 8'h52;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_N  = 8'h6E;
    localparam logic [7:0] CH_LO_G  = 8'h67;
    localparam logic [7:0] CH_LO_E  = 8'h65;

    localparam logic [3:0] PH_START   = 4'd0;
    localparam logic [3:0] PH_O       = 4'd1;
    localparam logic [3:0] PH_ON      = 4'd2;
    localparam logic [3:0] PH_OF      = 4'd3;
    localparam logic [3:0] PH_OFF     = 4'd4;
    localparam logic [3:0] PH_R       = 4'd5;
    localparam logic [3:0] PH_RA      = 4'd6;
    localparam logic [3:0] PH_RAN     = 4'd7;
    localparam logic [3:0] PH_RANG    = 4'd8;
    localparam logic [3:0] PH_RANGE   = 4'd9;
    localparam logic [3:0] PH_WS      = 4'd10;
    localparam logic [3:0] PH_SIGN    = 4'd11;
    localparam logic [3:0] PH_DIGITS  = 4'd12;
    localparam logic [3:0] PH_NUMDONE = 4'd13;
    localparam logic [3:0] PH_DEAD    = 4'd14;
    localparam logic [3:0] PH_ONEND   = 4'd15;

    typedef struct packed {
        logic [3:0]  phase;
        logic [16:0] accum;
        logic        negative;
    } t_match;

    typedef struct packed {
        logic        present;
        logic [15:0] dist_cm;
        logic        updated;
        logic        occupied;
    } t_result;

    // accumulate one decimal digit, saturating just above the 16-bit range
    function automatic logic [16:0] add_digit(logic [16:0] acc, logic [7:0] c);
        logic [19:0] v;
        v = ({3'b000, acc} << 3) + ({3'b000, acc} << 1) + {16'd0, c[3:0]};
        return (v > {3'b000, ACC_SAT}) ? ACC_SAT : v[16:0];
    endfunction

    function automatic t_match match_char(t_match m, logic [7:0] c);
        t_match r;
        logic   is_ws;
        logic   is_dig;
        r      = m;
        is_ws  = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
        is_dig = (c >= CH_ZERO) && (c <= CH_NINE);
        if (c == CH_NUL) begin
            // zero byte closes the text for matching
            case (m.phase)
                PH_ON:                           r.phase = PH_ONEND;
                PH_WS, PH_SIGN, PH_DIGITS:       r.phase = PH_NUMDONE;
                PH_OFF, PH_NUMDONE, PH_ONEND:    r.phase = m.phase;
                default:                         r.phase = PH_DEAD;
            endcase
        end else begin
            case (m.phase)
                PH_START: r.phase = (c == CH_UP_O) ? PH_O :
                                    ((c == CH_UP_R) ? PH_R : PH_DEAD);
                PH_O:     r.phase = (c == CH_UP_N) ? PH_ON :
                                    ((c == CH_UP_F) ? PH_OF : PH_DEAD);
                PH_ON:    r.phase = PH_DEAD;
                PH_OF:    r.phase = (c == CH_UP_F)  ? PH_OFF   : PH_DEAD;
                PH_R:     r.phase = (c == CH_LO_A)  ? PH_RA    : PH_DEAD;
                PH_RA:    r.phase = (c == CH_LO_N)  ? PH_RAN   : PH_DEAD;
                PH_RAN:   r.phase = (c == CH_LO_G)  ? PH_RANG  : PH_DEAD;
                PH_RANG:  r.phase = (c == CH_LO_E)  ? PH_RANGE : PH_DEAD;
                PH_RANGE: r.phase = (c == CH_SPACE) ? PH_WS    : PH_DEAD;
                PH_WS: begin
                    if (is_ws) begin
                        r.phase = PH_WS;
                    end else if (c == CH_PLUS) begin
                        r.phase = PH_SIGN;
                    end else if (c == CH_MINUS) begin
                        r.negative = 1'b1;
                        r.phase    = PH_SIGN;
                    end else if (is_dig) begin
                        r.accum = add_digit(m.accum, c);
                        r.phase = PH_DIGITS;
                    end else begin
                        r.phase = PH_NUMDONE;
                    end
                end
                PH_SIGN, PH_DIGITS: begin
                    if (is_dig) begin
                        r.accum = add_digit(m.accum, c);
                        r.phase = PH_DIGITS;
                    end else begin
                        r.phase = PH_NUMDONE;
                    end
                end
                default: r.phase = m.phase;
            endcase
        end
        return r;
    endfunction

endpackage

// ===== src/radar_text_line_presence_parser.sv =====
// radar text line parser: presence, range and staleness from a byte stream
/*
 * One item (a received byte plus the current millisecond time) is taken every
 * clock cycle. The line matcher, the decimal accumulator and the staleness
 * compare all settle in the cycle the item is accepted, and its result sits in
 * the output register from the next cycle on. A second result stage behind the
 * output register keeps input ready high while one result waits; input ready
 * drops only when both stages are full. The staleness limit may be rewritten
 * at any time the block is idle; its port is always ready.
 */
module radar_text_line_presence_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_rx_byte,
    input  logic [31:0] i_now_ms,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_present,
    output logic [15:0] o_dist_cm,
    output logic        o_updated,
    output logic        o_occupied,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data
);
    import rtlp_pkg::*;

    logic [31:0]      r_limit;
    logic [CNT_W-1:0] r_char_count, n_char_count;
    t_match           r_match, n_match;
    logic             r_pending_cr, n_pending_cr;
    logic             r_present, n_present;
    logic [15:0]      r_range, n_range;
    logic [31:0]      r_last_time, n_last_time;

    logic    r_out_valid, r_skid_valid;
    t_result r_out, r_skid;
    t_result n_res;

    logic   accept, out_take, upd;
    t_match cr_match;
    logic [31:0] age;

    assign o_ready     = !r_skid_valid;
    assign o_cfg_ready = 1'b1;
    assign accept      = i_valid && o_ready;
    assign out_take    = r_out_valid && i_ready;

    always_comb begin
        n_char_count = r_char_count;
        n_match      = r_match;
        n_pending_cr = r_pending_cr;
        n_present    = r_present;
        n_range      = r_range;
        n_last_time  = r_last_time;
        upd          = 1'b0;
        // a held cr turns out not to end the line, so it is matched first
        cr_match     = r_pending_cr ? match_char(r_match, CH_CR) : r_match;

        if (i_rx_byte == CH_LF) begin
            if (r_char_count != '0) begin
                if (r_match.phase == PH_ON || r_match.phase == PH_ONEND) begin
                    n_present = 1'b1;
                    upd       = 1'b1;
                end else if (r_match.phase == PH_OFF) begin
                    n_present = 1'b0;
                    n_range   = '0;
                    upd       = 1'b1;
                end else if (r_match.phase inside {[PH_WS:PH_NUMDONE]}) begin
                    if (!r_match.accum[16] &&
                        !(r_match.negative && r_match.accum != '0)) begin
                        n_range = r_match.accum[15:0];
                        upd     = 1'b1;
                    end
                end
            end
            if (upd) begin
                n_last_time = i_now_ms;
            end
            n_char_count = '0;
            n_match      = '{phase: PH_START, accum: '0, negative: 1'b0};
            n_pending_cr = 1'b0;
        end else if (r_char_count < CNT_LAST) begin
            if (i_rx_byte == CH_CR) begin
                n_match      = cr_match;
                n_pending_cr = 1'b1;
            end else begin
                n_match      = match_char(cr_match, i_rx_byte);
                n_pending_cr = 1'b0;
            end
            n_char_count = r_char_count + 1'b1;
        end else begin
            // overlong line: drop it together with this byte
            n_char_count = '0;
            n_match      = '{phase: PH_START, accum: '0, negative: 1'b0};
            n_pending_cr = 1'b0;
        end

        age               = i_now_ms - n_last_time;
        n_res.present     = n_present;
        n_res.dist_cm     = n_range;
        n_res.updated     = upd;
        n_res.occupied    = n_present && (age <= r_limit);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit      <= LIMIT_RESET;
            r_char_count <= '0;
            r_match      <= '{phase: PH_START, accum: '0, negative: 1'b0};
            r_pending_cr <= 1'b0;
            r_present    <= 1'b0;
            r_range      <= '0;
            r_last_time  <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_limit <= i_cfg_data;
            end
            if (accept) begin
                r_char_count <= n_char_count;
                r_match      <= n_match;
                r_pending_cr <= n_pending_cr;
                r_present    <= n_present;
                r_range      <= n_range;
                r_last_time  <= n_last_time;
            end
        end
    end

    // two-deep result buffer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || out_take) begin
            r_out_valid  <= r_skid_valid || accept;
            r_skid_valid <= 1'b0;
        end else if (accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || out_take) begin
            r_out <= r_skid_valid ? r_skid : n_res;
        end
        if (accept && !(!r_out_valid || out_take)) begin
            r_skid <= n_res;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_present  = r_out.present;
    assign o_dist_cm  = r_out.dist_cm;
    assign o_updated  = r_out.updated;
    assign o_occupied = r_out.occupied;

endmodule
